// ===== src/wads_pkg.sv =====
// ----------------------------------------------------------------------------
// wads_pkg
// Shared types and constants of the weekly alarm day scheduler.
// ----------------------------------------------------------------------------
package wads_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutUserW = 2;

  localparam logic MODE_PROGRAM = 1'b0;
  localparam logic MODE_ROTATE  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCHEDULE_ENABLED = 2'd0,
    CFG_WEEKDAY_MASK     = 2'd1,
    CFG_ALARM_HOUR       = 2'd2,
    CFG_ALARM_MINUTE     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic       enabled;
    logic [6:0] mask;
    logic [5:0] hour;
    logic [6:0] minute;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [2:0] weekday;
    logic [5:0] hour;
    logic [6:0] minute;
  } in_item_t;

  typedef struct packed {
    logic       written;
    logic       error;
    logic [7:0] a1_day;
    logic [7:0] a1_hour;
    logic [7:0] a1_minute;
    logic [7:0] a2_day;
    logic [7:0] a2_hour;
    logic [7:0] a2_minute;
    logic       held_we;
    logic [2:0] held_nxt;
  } plan_t;

endpackage

// ===== src/weekly_alarm_day_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// weekly_alarm_day_scheduler_unit
// Plans and encodes the two weekly power-on alarm register triples.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_index/cfg_wdata write enable, mask, alarm hour and minute;
//   write only while no item is in flight.
//   in_* carries one event item: tuser is the mode (program or rotate),
//   tdata the current weekday, hour and minute.
//   out_* returns one result item per event: tuser holds the written and
//   error flags, tdata the six alarm register bytes.
// Pipeline: an accepted item passes the input register, then the result
//   register, with the planning logic between them; out_tvalid rises when
//   the item is loaded into the result register.
// Throughput: one item per cycle; the input stage keeps taking items while
//   the result register is free or being drained in the same cycle.
// Reset clears the configuration, the held alarm 1 day and both stages.
// When the receiver stalls the result holds, the input stage fills, and
//   in_tready then drops until out_tready returns.
// ----------------------------------------------------------------------------
module weekly_alarm_day_scheduler_unit import wads_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,  // current_weekday[2:0], current_hour[8:3], current_minute[15:9]
  input  logic                in_tuser,  // mode
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata, // a1 day, a1 hour, a1 minute, a2 day, a2 hour, a2 minute
  output logic [OutUserW-1:0] out_tuser  // alarms_written[0], error[1]
);

  cfg_t     cfg;
  plan_t    plan;
  in_item_t s1_item_r;
  logic     s1_valid_r;
  logic     out_valid_r;
  logic [OutDataW-1:0] out_tdata_r;
  logic [OutUserW-1:0] out_tuser_r;
  logic [2:0] held_r;
  logic     s2_load;
  logic     s1_fire;
  logic     in_fire;

  wads_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  wads_planner u_planner (
    .cfg_i  (cfg),
    .item_i (s1_item_r),
    .held_i (held_r),
    .plan_o (plan)
  );

  assign s2_load   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s2_load;
  assign in_tready = !s1_valid_r || s2_load;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      held_r      <= 3'd0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire && plan.held_we) begin
        held_r <= plan.held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.mode    <= in_tuser;
      s1_item_r.weekday <= in_tdata[2:0];
      s1_item_r.hour    <= in_tdata[8:3];
      s1_item_r.minute  <= in_tdata[15:9];
    end
    if (s1_fire) begin
      out_tdata_r <= {plan.a2_minute, plan.a2_hour, plan.a2_day,
                      plan.a1_minute, plan.a1_hour, plan.a1_day};
      out_tuser_r <= {plan.error, plan.written};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== src/wads_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// wads_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module wads_cfg_regs import wads_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCHEDULE_ENABLED: cfg_nxt.enabled = cfg_wdata[0];
        CFG_WEEKDAY_MASK:     cfg_nxt.mask    = cfg_wdata[6:0];
        CFG_ALARM_HOUR:       cfg_nxt.hour    = cfg_wdata[5:0];
        CFG_ALARM_MINUTE:     cfg_nxt.minute  = cfg_wdata[6:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== src/wads_planner.sv =====
// ----------------------------------------------------------------------------
// wads_planner
// Day search, time compare and alarm register encoding for one item.
// ----------------------------------------------------------------------------
module wads_planner import wads_pkg::*; (
  input  cfg_t     cfg_i,
  input  in_item_t item_i,
  input  logic [2:0] held_i,
  output plan_t    plan_o
);

  function automatic logic [2:0] next_day(input logic [6:0] mask, input logic [2:0] start);
    logic [2:0] s;
    logic [3:0] idx;
    logic [2:0] d;
    s = (start == 3'd7) ? 3'd0 : start;
    d = 3'd0;
    for (int o = 6; o >= 0; o--) begin
      idx = {1'b0, s} + 4'(o);
      if (idx >= 4'd7) idx = idx - 4'd7;
      if (mask[idx[2:0]]) d = idx[2:0];
    end
    return d;
  endfunction

  function automatic logic [2:0] inc_day(input logic [2:0] d);
    return (d == 3'd6) ? 3'd0 : d + 3'd1;
  endfunction

  function automatic logic [5:0] hour_order(input logic [5:0] h);
    if (h == 6'h12) return 6'h00;
    if (h == 6'h32) return 6'h12;
    return h;
  endfunction

  function automatic logic [7:0] hour_to_chip(input logic [5:0] h);
    if (h == 6'h12) return 8'h00;
    if (h == 6'h32) return 8'h40;
    if (h > 6'h20) return {2'b00, h} + 8'h20;
    return {2'b00, h};
  endfunction

  function automatic logic [7:0] rev_en(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r | 8'h01;
  endfunction

  logic       mask_empty;
  logic       mask_single;
  logic       mask_multi;
  logic       passed;
  logic [2:0] day_f0;
  logic [2:0] day_first;
  logic [2:0] day_second;
  logic [7:0] hour_byte;
  logic [7:0] minute_byte;

  assign mask_empty  = (cfg_i.mask == 7'd0);
  assign mask_single = !mask_empty && ((cfg_i.mask & (cfg_i.mask - 7'd1)) == 7'd0);
  assign mask_multi  = !mask_empty && !mask_single;

  assign passed = (hour_order(item_i.hour) > hour_order(cfg_i.hour)) ||
                  ((hour_order(item_i.hour) == hour_order(cfg_i.hour)) &&
                   (item_i.minute >= cfg_i.minute));

  assign day_f0     = next_day(cfg_i.mask, item_i.weekday);
  assign day_first  = ((day_f0 == item_i.weekday) && passed) ?
                      next_day(cfg_i.mask, inc_day(day_f0)) : day_f0;
  assign day_second = next_day(cfg_i.mask, inc_day(day_first));

  assign hour_byte   = rev_en(hour_to_chip(cfg_i.hour));
  assign minute_byte = rev_en({1'b0, cfg_i.minute});

  always_comb begin
    plan_o = '0;
    if (item_i.mode == MODE_PROGRAM) begin
      if (!cfg_i.enabled) begin
        plan_o.written  = 1'b1;
        plan_o.held_we  = 1'b1;
        plan_o.held_nxt = 3'd0;
      end else if (mask_empty) begin
        plan_o.error = 1'b1;
      end else if (mask_single) begin
        plan_o.written   = 1'b1;
        plan_o.a1_day    = rev_en({5'd0, day_f0});
        plan_o.a1_hour   = hour_byte;
        plan_o.a1_minute = minute_byte;
        plan_o.held_we   = 1'b1;
        plan_o.held_nxt  = day_f0;
      end else begin
        plan_o.written   = 1'b1;
        plan_o.a1_day    = rev_en({5'd0, day_first});
        plan_o.a1_hour   = hour_byte;
        plan_o.a1_minute = minute_byte;
        plan_o.a2_day    = rev_en({5'd0, day_second});
        plan_o.a2_hour   = hour_byte;
        plan_o.a2_minute = minute_byte;
        plan_o.held_we   = 1'b1;
        plan_o.held_nxt  = day_first;
      end
    end else if (cfg_i.enabled && mask_multi && (held_i != day_first)) begin
      plan_o.written   = 1'b1;
      plan_o.a1_day    = rev_en({5'd0, day_first});
      plan_o.a1_hour   = hour_byte;
      plan_o.a1_minute = minute_byte;
      plan_o.a2_day    = rev_en({5'd0, day_second});
      plan_o.a2_hour   = hour_byte;
      plan_o.a2_minute = minute_byte;
      plan_o.held_we   = 1'b1;
      plan_o.held_nxt  = day_first;
    end
  end

endmodule
